// ===== src/geo_grid_nearest_lookup_defines.svh =====
// Assertion macros shared by the grid lookup RTL.
`ifndef GEO_GRID_NEAREST_LOOKUP_DEFINES_SVH
`define GEO_GRID_NEAREST_LOOKUP_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define GGNL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define GGNL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define GGNL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ggnl_pkg.sv =====
// Shared constants, codes and entry types of the grid lookup.
package ggnl_pkg;

  // Table sizes
  localparam int MAX_POINTS = 4096;
  localparam int MAX_ROWS   = 512;

  localparam int PT_AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PT_CW  = $clog2(MAX_POINTS + 1);
  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int IDX_W  = (PT_AW > ROW_AW) ? PT_AW : ROW_AW;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int KIND_W = 6;
  localparam int LAT_W  = 18;
  localparam int LON_W  = 19;
  localparam int VEL_W  = 12;
  localparam int PVEL_W = 11;
  localparam int STAT_W = 3;
  localparam int ALU_W  = 21;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SETDEF = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DEFAULT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_MAP_OFF  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_KIND = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECTED = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd6;

  // Limits
  localparam logic [KIND_W-1:0]        KIND_SUPPORTED = 6'd30;
  localparam logic [ALU_W-1:0]         NEAR_LIMIT     = 21'd100;
  localparam logic signed [LAT_W-1:0]  LAT_MAX        = 18'sd90000;
  localparam logic signed [LAT_W-1:0]  LAT_MIN        = -18'sd90000;
  localparam logic signed [LON_W-1:0]  LON_MAX        = 19'sd180000;
  localparam logic signed [LON_W-1:0]  LON_MIN        = -19'sd180000;
  localparam logic signed [VEL_W-1:0]  VEL_MIN        = 12'sd150;
  localparam logic signed [VEL_W-1:0]  VEL_MAX        = 12'sd2000;
  localparam logic signed [VEL_W-1:0]  VEL_NONE       = -12'sd1;

  // Register map
  localparam int REG_DEFAULT_VELOCITY = 0;

  // One grid point as stored
  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [PVEL_W-1:0]       vel;
  } point_t;

  // One row: index of its first point and its latitude
  typedef struct packed {
    logic [PT_AW-1:0]        start;
    logic signed [LAT_W-1:0] lat;
  } row_t;

endpackage

// ===== src/ggnl_if.sv =====
// Command and response channel interfaces of the grid lookup.
interface ggnl_cmd_if;
  import ggnl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [KIND_W-1:0]        velocity_kind;
  logic signed [LAT_W-1:0]  latitude;
  logic signed [LON_W-1:0]  longitude;
  logic signed [VEL_W-1:0]  velocity_value;

  modport source (
    output valid, command, velocity_kind, latitude, longitude, velocity_value,
    input  ready
  );
  modport sink (
    input  valid, command, velocity_kind, latitude, longitude, velocity_value,
    output ready
  );
endinterface

interface ggnl_rsp_if;
  import ggnl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  velocity_out;
  logic [STAT_W-1:0]        status;

  modport source (output valid, velocity_out, status, input ready);
  modport sink (input valid, velocity_out, status, output ready);
endinterface

// ===== src/ggnl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ggnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                           wr_data_i,
  input  logic                                       rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                           rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/geo_grid_nearest_lookup.sv =====
// Top level: nearest grid point velocity lookup with table load and query sequencer.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-----------------------------------------------
//   cmd_i    | in  | valid/ready      | command, velocity_kind, latitude, longitude,
//            |     |                  | velocity_value
//   rsp_o    | out | valid/ready      | velocity_out, status
//   apb      | in  | psel/penable     | paddr, pwdata, prdata (default_velocity @ 0)
//
// Clear, load and set-default commands go through S_OUT to the response register.
// A query walks the rows, then the chosen row, with one shared subtractor and
// one registered RAM read per step. Each binary search step has a read issue
// state and a compare state. Reset is asynchronous and active low, empties the
// table and sets default_velocity to -1; no clearing pass is needed. The command
// side takes a new transfer while a response is still held for the sink.
module geo_grid_nearest_lookup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ggnl_cmd_if.sink                         cmd_i,
  ggnl_rsp_if.source                       rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ggnl_pkg::APB_AW-1:0]      paddr,
  input  logic [ggnl_pkg::APB_DW-1:0]      pwdata,
  output logic [ggnl_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import ggnl_pkg::*;
  `include "geo_grid_nearest_lookup_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE,
    S_RS,
    S_RS_CMP,
    S_RLO_D,
    S_RHI_D,
    S_RPICK,
    S_RB1_D,
    S_RB2_D,
    S_PS,
    S_PS_CMP,
    S_PLO_D,
    S_PHI_D,
    S_PPICK,
    S_PLAT_D,
    S_PLON_D,
    S_OUT
  } state_e;

  // Control state
  state_e                   state_q, state_d;
  logic [PT_CW-1:0]         point_count_q, point_count_d;
  logic [ROW_CW-1:0]        row_count_q, row_count_d;
  logic signed [LAT_W-1:0]  prev_lat_q, prev_lat_d;
  logic                     row_open_q, row_open_d;
  logic signed [VEL_W-1:0]  default_q, default_d;
  logic                     rsp_valid_q, rsp_valid_d;

  // Search and result payload
  logic [IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, sel_q, sel_d;
  logic [ALU_W-1:0]         dist_lo_q, dist_lo_d, dist_hi_q, dist_hi_d;
  logic signed [LAT_W-1:0]  qlat_q, qlat_d;
  logic signed [LON_W-1:0]  qlon_q, qlon_d;
  logic                     near_lat_q, near_lat_d;
  logic signed [VEL_W-1:0]  res_vel_q, res_vel_d, rsp_vel_q, rsp_vel_d;
  logic [STAT_W-1:0]        res_st_q, res_st_d, rsp_st_q, rsp_st_d;

  // Memory ports
  logic                     pt_wr_en, pt_rd_en, row_wr_en, row_rd_en;
  logic [PT_AW-1:0]         pt_rd_addr;
  logic [ROW_AW-1:0]        row_rd_addr;
  point_t                   pt_wr_data, pt_rd_data;
  row_t                     row_wr_data, row_rd_data;

  // Shared subtractor
  logic signed [ALU_W-1:0]  alu_a, alu_b, alu_diff;
  logic                     alu_neg;
  logic [ALU_W-1:0]         alu_abs;

  // Misc decode
  logic                     cmd_xfer, rsp_xfer, apb_wr;
  logic [IDX_W-1:0]         span, mid;
  logic [IDX_W:0]           row_nxt;
  logic                     last_row;
  logic [PT_CW-1:0]         row_end;
  logic                     new_row, load_bad, load_full, kind_ok;

  ggnl_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pt_wr_en),
    .wr_addr_i (point_count_q[PT_AW-1:0]),
    .wr_data_i (pt_wr_data),
    .rd_en_i   (pt_rd_en),
    .rd_addr_i (pt_rd_addr),
    .rd_data_o (pt_rd_data)
  );

  ggnl_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (row_wr_en),
    .wr_addr_i (row_count_q[ROW_AW-1:0]),
    .wr_data_i (row_wr_data),
    .rd_en_i   (row_rd_en),
    .rd_addr_i (row_rd_addr),
    .rd_data_o (row_rd_data)
  );

  // Handshakes
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign rsp_xfer    = rsp_valid_q && rsp_o.ready;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.velocity_out = rsp_vel_q;
  assign rsp_o.status       = rsp_st_q;

  // APB register access
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1] == REG_DEFAULT_VELOCITY[0]);
  assign prdata = (paddr[APB_AW-1] == REG_DEFAULT_VELOCITY[0]) ?
                  {{(APB_DW-VEL_W){default_q[VEL_W-1]}}, default_q} : '0;

  // Select subtractor operands by sequencer step
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_RS_CMP, S_RLO_D, S_RHI_D: begin
        alu_a = {{(ALU_W-LAT_W){qlat_q[LAT_W-1]}}, qlat_q};
        alu_b = {{(ALU_W-LAT_W){row_rd_data.lat[LAT_W-1]}}, row_rd_data.lat};
      end
      S_PS_CMP, S_PLO_D, S_PHI_D, S_PLON_D: begin
        alu_a = {{(ALU_W-LON_W){qlon_q[LON_W-1]}}, qlon_q};
        alu_b = {{(ALU_W-LON_W){pt_rd_data.lon[LON_W-1]}}, pt_rd_data.lon};
      end
      S_RPICK, S_PPICK: begin
        alu_a = dist_lo_q;
        alu_b = dist_hi_q;
      end
      S_PLAT_D: begin
        alu_a = {{(ALU_W-LAT_W){qlat_q[LAT_W-1]}}, qlat_q};
        alu_b = {{(ALU_W-LAT_W){pt_rd_data.lat[LAT_W-1]}}, pt_rd_data.lat};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = alu_a - alu_b;
  assign alu_neg  = alu_diff[ALU_W-1];
  assign alu_abs  = alu_neg ? ALU_W'(-alu_diff) : alu_diff;

  // Search helpers
  assign span     = hi_q - lo_q;
  assign mid      = lo_q + (span >> 1);
  assign row_nxt  = {1'b0, sel_q} + (IDX_W+1)'(1);
  assign last_row = (row_nxt >= (IDX_W+1)'(row_count_q));
  assign row_end  = last_row ? point_count_q : PT_CW'(row_rd_data.start);

  // Load checks
  assign new_row   = !row_open_q || (cmd_i.latitude != prev_lat_q);
  assign load_bad  = (cmd_i.latitude < LAT_MIN) || (cmd_i.latitude > LAT_MAX) ||
                     (cmd_i.longitude < LON_MIN) || (cmd_i.longitude > LON_MAX) ||
                     (cmd_i.velocity_value < VEL_MIN) || (cmd_i.velocity_value > VEL_MAX);
  assign load_full = (point_count_q >= PT_CW'(MAX_POINTS)) ||
                     (new_row && (row_count_q >= ROW_CW'(MAX_ROWS)));
  assign kind_ok   = (cmd_i.velocity_kind == KIND_SUPPORTED);

  assign pt_wr_data.lat  = cmd_i.latitude;
  assign pt_wr_data.lon  = cmd_i.longitude;
  assign pt_wr_data.vel  = cmd_i.velocity_value[PVEL_W-1:0];
  assign row_wr_data.start = point_count_q[PT_AW-1:0];
  assign row_wr_data.lat   = cmd_i.latitude;

  // Sequencer next state
  always_comb begin
    state_d       = state_q;
    point_count_d = point_count_q;
    row_count_d   = row_count_q;
    prev_lat_d    = prev_lat_q;
    row_open_d    = row_open_q;
    default_d     = default_q;
    rsp_valid_d   = rsp_valid_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    mid_d         = mid_q;
    sel_d         = sel_q;
    dist_lo_d     = dist_lo_q;
    dist_hi_d     = dist_hi_q;
    qlat_d        = qlat_q;
    qlon_d        = qlon_q;
    near_lat_d    = near_lat_q;
    res_vel_d     = res_vel_q;
    res_st_d      = res_st_q;
    rsp_vel_d     = rsp_vel_q;
    rsp_st_d      = rsp_st_q;
    pt_wr_en      = 1'b0;
    row_wr_en     = 1'b0;
    pt_rd_en      = 1'b0;
    row_rd_en     = 1'b0;
    pt_rd_addr    = lo_q[PT_AW-1:0];
    row_rd_addr   = lo_q[ROW_AW-1:0];

    // Drop the response once taken
    if (rsp_xfer) begin
      rsp_valid_d = 1'b0;
    end

    if (apb_wr) begin
      default_d = pwdata[VEL_W-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_xfer) begin
          res_vel_d = '0;
          res_st_d  = ST_OK;
          qlat_d    = cmd_i.latitude;
          qlon_d    = cmd_i.longitude;
          state_d   = S_OUT;
          case (cmd_i.command)
            CMD_CLEAR: begin
              point_count_d = '0;
              row_count_d   = '0;
              prev_lat_d    = '0;
              row_open_d    = 1'b0;
            end
            CMD_LOAD: begin
              if (load_bad) begin
                res_st_d = ST_REJECTED;
              end else if (load_full) begin
                res_st_d = ST_FULL;
              end else begin
                pt_wr_en      = 1'b1;
                point_count_d = point_count_q + PT_CW'(1);
                if (new_row) begin
                  row_wr_en   = 1'b1;
                  row_count_d = row_count_q + ROW_CW'(1);
                  row_open_d  = 1'b1;
                  prev_lat_d  = cmd_i.latitude;
                end
              end
            end
            CMD_QUERY: begin
              if (!kind_ok) begin
                res_vel_d = VEL_NONE;
                res_st_d  = ST_BAD_KIND;
              end else if (default_q[VEL_W-1]) begin
                res_vel_d = default_q;
                res_st_d  = ST_MAP_OFF;
              end else if (point_count_q == '0 || row_count_q == '0) begin
                res_vel_d = default_q;
                res_st_d  = ST_EMPTY;
              end else begin
                lo_d    = '0;
                hi_d    = IDX_W'(row_count_q - ROW_CW'(1));
                state_d = S_RS;
              end
            end
            CMD_SETDEF: begin
              if (!kind_ok) begin
                res_vel_d = VEL_NONE;
                res_st_d  = ST_BAD_KIND;
              end else begin
                default_d = cmd_i.velocity_value;
                res_vel_d = cmd_i.velocity_value;
              end
            end
            default: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end

      // Row search by latitude
      S_RS: begin
        row_rd_en = 1'b1;
        if (span > IDX_W'(1)) begin
          row_rd_addr = mid[ROW_AW-1:0];
          mid_d       = mid;
          state_d     = S_RS_CMP;
        end else if (span != '0) begin
          state_d = S_RLO_D;
        end else begin
          sel_d   = lo_q;
          state_d = S_RB1_D;
        end
      end
      S_RS_CMP: begin
        if (alu_neg) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        state_d = S_RS;
      end
      S_RLO_D: begin
        dist_lo_d   = alu_abs;
        row_rd_en   = 1'b1;
        row_rd_addr = hi_q[ROW_AW-1:0];
        state_d     = S_RHI_D;
      end
      S_RHI_D: begin
        dist_hi_d = alu_abs;
        state_d   = S_RPICK;
      end
      S_RPICK: begin
        // Upper row wins a tie
        sel_d       = alu_neg ? lo_q : hi_q;
        row_rd_en   = 1'b1;
        row_rd_addr = alu_neg ? lo_q[ROW_AW-1:0] : hi_q[ROW_AW-1:0];
        state_d     = S_RB1_D;
      end
      S_RB1_D: begin
        lo_d        = IDX_W'(row_rd_data.start);
        row_rd_en   = 1'b1;
        row_rd_addr = row_nxt[ROW_AW-1:0];
        state_d     = S_RB2_D;
      end
      S_RB2_D: begin
        hi_d    = IDX_W'(row_end - PT_CW'(1));
        state_d = S_PS;
      end

      // Point search by longitude within the row
      S_PS: begin
        pt_rd_en = 1'b1;
        if (span > IDX_W'(1)) begin
          pt_rd_addr = mid[PT_AW-1:0];
          mid_d      = mid;
          state_d    = S_PS_CMP;
        end else if (span != '0) begin
          state_d = S_PLO_D;
        end else begin
          state_d = S_PLAT_D;
        end
      end
      S_PS_CMP: begin
        if (alu_neg) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        state_d = S_PS;
      end
      S_PLO_D: begin
        dist_lo_d  = alu_abs;
        pt_rd_en   = 1'b1;
        pt_rd_addr = hi_q[PT_AW-1:0];
        state_d    = S_PHI_D;
      end
      S_PHI_D: begin
        dist_hi_d = alu_abs;
        state_d   = S_PPICK;
      end
      S_PPICK: begin
        pt_rd_en   = 1'b1;
        pt_rd_addr = alu_neg ? lo_q[PT_AW-1:0] : hi_q[PT_AW-1:0];
        state_d    = S_PLAT_D;
      end

      // Near check on the chosen point, read data held
      S_PLAT_D: begin
        near_lat_d = (alu_abs < NEAR_LIMIT);
        state_d    = S_PLON_D;
      end
      S_PLON_D: begin
        if (near_lat_q && (alu_abs < NEAR_LIMIT)) begin
          res_vel_d = {{(VEL_W-PVEL_W){1'b0}}, pt_rd_data.vel};
          res_st_d  = ST_OK;
        end else begin
          res_vel_d = default_q;
          res_st_d  = ST_DEFAULT;
        end
        state_d = S_OUT;
      end

      // Hand the result to the output register when it is free
      S_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_vel_d   = res_vel_q;
          rsp_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= '0;
      row_count_q   <= '0;
      prev_lat_q    <= '0;
      row_open_q    <= 1'b0;
      default_q     <= VEL_NONE;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      point_count_q <= point_count_d;
      row_count_q   <= row_count_d;
      prev_lat_q    <= prev_lat_d;
      row_open_q    <= row_open_d;
      default_q     <= default_d;
      rsp_valid_q   <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    sel_q      <= sel_d;
    dist_lo_q  <= dist_lo_d;
    dist_hi_q  <= dist_hi_d;
    qlat_q     <= qlat_d;
    qlon_q     <= qlon_d;
    near_lat_q <= near_lat_d;
    res_vel_q  <= res_vel_d;
    res_st_q   <= res_st_d;
    rsp_vel_q  <= rsp_vel_d;
    rsp_st_q   <= rsp_st_d;
  end

  // Checks
  `GGNL_ASSERT_ALWAYS(a_rows_le_points, PT_CW'(row_count_q) <= point_count_q, "rows > points")
  `GGNL_ASSERT_IMPL(a_search_order, state_q == S_RS || state_q == S_PS, lo_q <= hi_q, "search bounds crossed")
  `GGNL_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid_q), $past(state_q == S_OUT), "response without result")
  `GGNL_ASSERT_NEXT(a_count_grows, cmd_xfer && cmd_i.command != CMD_CLEAR, point_count_q >= $past(point_count_q), "point count dropped")

endmodule
